@@ sv/sba_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the sparse block aggregator.
package sba_pkg;

    localparam int ID_W    = 24;
    localparam int SUM_W   = 40;
    localparam int MOD_STEPS = ID_W;

    // Operation codes
    localparam logic [2:0] OP_ELEMENT  = 3'd0;
    localparam logic [2:0] OP_PREPARE  = 3'd1;
    localparam logic [2:0] OP_READ_COL = 3'd2;
    localparam logic [2:0] OP_READ_SUM = 3'd3;
    localparam logic [2:0] OP_RESET    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WORKERS = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_BLKLEN  = 2'd2;

    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
    } entry_t;

    localparam entry_t BLOCK_INF = '0;

    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        worker_id;
        logic [2:0]        column;
        logic [ID_W-1:0]   block_id;
        logic              block_valid;
        logic [ID_W-1:0]   next_id;
        logic              next_valid;
        logic [7:0]        element_index;
        logic signed [31:0] gradient;
        logic              packet_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    all_in;
        logic [4:0]              expected_senders;
        logic [3:0]              valid_columns;
        logic [ID_W-1:0]         out_block_id;
        logic                    out_block_valid;
        logic [ID_W-1:0]         request_id;
        logic                    request_valid;
        logic signed [SUM_W-1:0] sum_value;
    } out_item_t;

endpackage

@@ sv/sba_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces of the sparse block aggregator.
interface sba_in_if;
    logic               valid;
    logic               ready;
    sba_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sba_out_if;
    logic               valid;
    logic               ready;
    sba_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/sparse_block_aggregator_top.sv @@
`timescale 1ns / 1ps
// Sparse block all-reduce aggregation node: sum store, request tracking, prepare walk.
//
// Channels: in_ch takes one request (element, prepare, read column, read sum,
// reset round) per handshake; out_ch returns exactly one result per request.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the block does not enforce it.
// One request is in work at a time; in_ch.ready is high only when idle.
// Steps per request, accept to result loaded in the output register:
//   element with a valid block: 24-step id modulo on the remainder unit,
//   then one read-modify-write of the sum memory port;
//   element without block or with bad fields, read column and other ops: straight
//   to the result; read sum: one sum memory read first; prepare: one next-table
//   read and one compare per entry; reset round: a clearing pass over the sum memory.
// Reset: a clearing pass zeroes all COLUMNS * BLOCK_LEN words of the sum memory
// before the first request is taken; configuration writes are taken meanwhile.
// Stall: a result waits in the output register; the next request is taken
// while it waits, and the finished result after it waits until out_ch.ready.
module sparse_block_aggregator_top #(
    parameter int MAX_WORKERS = 16,
    parameter int COLUMNS     = 8,
    parameter int BLOCK_LEN   = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    sba_in_if.sink           in_ch,
    sba_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_data
);

    localparam int WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int WCW = $clog2(MAX_WORKERS + 1);
    localparam int CW  = $clog2(COLUMNS + 1);
    localparam int LW  = $clog2(BLOCK_LEN + 1);
    localparam int RCW = $clog2(2 * MAX_WORKERS);
    localparam int NTD = MAX_WORKERS * COLUMNS;
    localparam int NTW = (NTD > 1) ? $clog2(NTD) : 1;
    localparam int SD  = COLUMNS * BLOCK_LEN;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int MCW = $clog2(sba_pkg::MOD_STEPS);
    localparam int RCV_MAX = 2 * MAX_WORKERS - 1;
    localparam logic signed [sba_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(sba_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [sba_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(sba_pkg::SUM_W-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SUMRD = 3'd3;
    localparam logic [2:0] S_ELWR  = 3'd4;
    localparam logic [2:0] S_PRRD  = 3'd5;
    localparam logic [2:0] S_PREV  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          state_reg;
    logic                clr_op_reg;
    logic [SAW-1:0]      clr_cnt_reg;
    logic [WCW-1:0]      wc_reg;
    logic [CW-1:0]       cc_reg;
    logic [LW-1:0]       bl_reg;
    logic [RCW-1:0]      rcv_reg;
    logic [WCW-1:0]      exp_reg;
    logic [MAX_WORKERS-1:0] marks_reg;
    sba_pkg::in_item_t   item_reg;
    logic [1:0]          res_status_reg;
    sba_pkg::entry_t     res_bid_reg;
    sba_pkg::entry_t     res_req_reg;
    logic [CW:0]         rem_reg;
    logic [sba_pkg::ID_W-1:0] mod_sh_reg;
    logic [MCW-1:0]      mod_cnt_reg;
    logic [WIW-1:0]      pj_reg;
    logic [CIW-1:0]      pi_reg;
    sba_pkg::entry_t     larger_reg;
    logic                out_vld_reg;
    sba_pkg::out_item_t  out_reg;

    sba_pkg::entry_t     cm_reg  [COLUMNS];
    sba_pkg::entry_t     agg_reg [COLUMNS];
    sba_pkg::entry_t     req_reg [COLUMNS];
    logic [NTD-1:0]      nt_vld_reg;

    // Memories
    logic [sba_pkg::ID_W-1:0]         nt_mem  [NTD];
    logic signed [sba_pkg::SUM_W-1:0] sum_mem [SD];
    logic [sba_pkg::ID_W-1:0]         nt_rd_reg;
    logic                             nt_rdv_reg;
    logic signed [sba_pkg::SUM_W-1:0] sum_rd_reg;

    function automatic sba_pkg::entry_t min_entry(sba_pkg::entry_t a, sba_pkg::entry_t b);
        sba_pkg::entry_t r;
        if (!a.vld)
            r = b;
        else if (!b.vld)
            r = a;
        else
            r = (a.id <= b.id) ? a : b;
        return r;
    endfunction

    // Decode the incoming request
    sba_pkg::in_item_t in_p;
    logic              accept;
    logic              in_bad_w;
    logic              in_bad_ce;
    logic              in_bad_c;
    logic [CIW-1:0]    in_col;
    logic [WIW-1:0]    in_w;
    logic [NTW-1:0]    in_nt_addr;

    assign in_p      = in_ch.payload;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept    = in_ch.valid && in_ch.ready;
    assign in_col    = CIW'(in_p.column);
    assign in_w      = WIW'(in_p.worker_id);
    assign in_bad_w  = (int'(in_p.worker_id) >= int'(wc_reg));
    assign in_bad_c  = (int'(in_p.column) >= int'(cc_reg));
    assign in_bad_ce = in_bad_c || (int'(in_p.element_index) >= int'(bl_reg));
    assign in_nt_addr = NTW'(int'(in_w) * COLUMNS + int'(in_col));

    // Latched request views
    logic [CIW-1:0]  it_col;
    logic [SAW-1:0]  sum_addr;
    assign it_col   = CIW'(item_reg.column);
    assign sum_addr = SAW'(int'(it_col) * BLOCK_LEN + int'(item_reg.element_index));

    // Remainder step: one quotient bit a cycle
    logic [CW:0] mod_t;
    logic [CW:0] rem_next;
    assign mod_t    = {rem_reg[CW-1:0], mod_sh_reg[sba_pkg::ID_W-1]};
    assign rem_next = (mod_t >= {1'b0, cc_reg}) ? (mod_t - {1'b0, cc_reg}) : mod_t;

    // Saturating sum update
    logic signed [sba_pkg::SUM_W:0]   sum_wide;
    logic signed [sba_pkg::SUM_W-1:0] sum_sat;
    always_comb
    begin
        sum_wide = {sum_rd_reg[sba_pkg::SUM_W-1], sum_rd_reg}
                   + (sba_pkg::SUM_W+1)'(item_reg.gradient);
        if (sum_wide[sba_pkg::SUM_W] != sum_wide[sba_pkg::SUM_W-1])
            sum_sat = sum_wide[sba_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[sba_pkg::SUM_W-1:0];
    end

    // Element checks at the write step
    sba_pkg::entry_t el_next;
    logic            el_mism;
    assign el_next = item_reg.next_valid ? '{vld: 1'b1, id: item_reg.next_id} : sba_pkg::BLOCK_INF;
    assign el_mism = (rem_reg != (CW+1)'(item_reg.column))
                     || (agg_reg[it_col].vld && (agg_reg[it_col].id != item_reg.block_id));

    // Prepare compare of one next-table entry
    sba_pkg::entry_t pr_e;
    sba_pkg::entry_t pr_m;
    logic            pr_hit;
    sba_pkg::entry_t larger_next;
    logic [NTW-1:0]  pr_addr;
    assign pr_e    = nt_rdv_reg ? '{vld: 1'b1, id: nt_rd_reg} : sba_pkg::BLOCK_INF;
    assign pr_m    = cm_reg[pi_reg];
    assign pr_hit  = pr_m.vld && (pr_e == pr_m);
    assign larger_next = pr_hit ? larger_reg : min_entry(larger_reg, pr_e);
    assign pr_addr = NTW'(int'(pj_reg) * COLUMNS + int'(pi_reg));

    // Count columns in use holding a valid block
    logic [CW-1:0] vcols;
    always_comb
    begin
        vcols = '0;
        for (int i = 0; i < COLUMNS; i++)
        begin
            if ((i < int'(cc_reg)) && agg_reg[i].vld)
                vcols = vcols + CW'(1);
        end
    end

    // Next-table memory: write on element 0, read during prepare
    always_ff @(posedge clk)
    begin
        if (accept && (in_p.op == sba_pkg::OP_ELEMENT) && !in_bad_w && !in_bad_ce
            && (in_p.element_index == 8'd0))
            nt_mem[in_nt_addr] <= in_p.next_id;
        nt_rd_reg  <= nt_mem[pr_addr];
        nt_rdv_reg <= nt_vld_reg[pr_addr];
    end

    // Sum memory: clearing sweep or element write, one read a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            sum_mem[clr_cnt_reg] <= '0;
        else if ((state_reg == S_ELWR) && item_reg.block_valid && !el_mism)
            sum_mem[sum_addr] <= sum_sat;
        sum_rd_reg <= sum_mem[sum_addr];
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_op_reg  <= 1'b0;
            clr_cnt_reg <= '0;
            wc_reg      <= WCW'(MAX_WORKERS);
            cc_reg      <= CW'(COLUMNS);
            bl_reg      <= LW'(BLOCK_LEN);
            rcv_reg     <= '0;
            exp_reg     <= WCW'(MAX_WORKERS);
            marks_reg   <= '0;
            nt_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
            mod_cnt_reg <= '0;
            pi_reg      <= '0;
            pj_reg      <= '0;
            for (int i = 0; i < COLUMNS; i++)
            begin
                cm_reg[i]  <= sba_pkg::BLOCK_INF;
                agg_reg[i] <= sba_pkg::BLOCK_INF;
                req_reg[i] <= sba_pkg::BLOCK_INF;
            end
        end
        else
        begin
            // Configuration writes, clamped to the supported range
            if (cfg_we)
            begin
                case (cfg_index)
                    sba_pkg::REG_WORKERS:
                    begin
                        if (cfg_data[4:0] == 5'd0)
                        begin
                            wc_reg  <= WCW'(1);
                            exp_reg <= WCW'(1);
                        end
                        else if (int'(cfg_data[4:0]) > MAX_WORKERS)
                        begin
                            wc_reg  <= WCW'(MAX_WORKERS);
                            exp_reg <= WCW'(MAX_WORKERS);
                        end
                        else
                        begin
                            wc_reg  <= WCW'(cfg_data[4:0]);
                            exp_reg <= WCW'(cfg_data[4:0]);
                        end
                    end
                    sba_pkg::REG_COLUMNS:
                    begin
                        if (cfg_data[3:0] == 4'd0)
                            cc_reg <= CW'(1);
                        else if (int'(cfg_data[3:0]) > COLUMNS)
                            cc_reg <= CW'(COLUMNS);
                        else
                            cc_reg <= CW'(cfg_data[3:0]);
                    end
                    sba_pkg::REG_BLKLEN:
                    begin
                        if (cfg_data == 9'd0)
                            bl_reg <= LW'(1);
                        else if (int'(cfg_data) > BLOCK_LEN)
                            bl_reg <= LW'(BLOCK_LEN);
                        else
                            bl_reg <= LW'(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Drop the output request once taken
            if (out_vld_reg && out_ch.ready)
                out_vld_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg       <= in_p;
                        res_status_reg <= sba_pkg::ST_OK;
                        res_bid_reg    <= sba_pkg::BLOCK_INF;
                        res_req_reg    <= sba_pkg::BLOCK_INF;
                        rem_reg        <= '0;
                        mod_sh_reg     <= in_p.block_id;
                        mod_cnt_reg    <= '0;
                        state_reg      <= S_DONE;
                        case (in_p.op)
                            sba_pkg::OP_ELEMENT:
                            begin
                                if (in_bad_w)
                                    res_status_reg <= sba_pkg::ST_BAD;
                                else
                                begin
                                    if (in_p.packet_end && (int'(rcv_reg) < RCV_MAX))
                                        rcv_reg <= rcv_reg + RCW'(1);
                                    if (in_bad_ce)
                                        res_status_reg <= sba_pkg::ST_BAD;
                                    else
                                    begin
                                        if (in_p.element_index == 8'd0)
                                            nt_vld_reg[in_nt_addr] <= in_p.next_valid;
                                        if (in_p.block_valid)
                                            state_reg <= S_MOD;
                                    end
                                end
                            end
                            sba_pkg::OP_PREPARE:
                            begin
                                if (WCW'(rcv_reg) != exp_reg || int'(rcv_reg) > MAX_WORKERS)
                                    res_status_reg <= sba_pkg::ST_EARLY;
                                else
                                begin
                                    exp_reg    <= '0;
                                    marks_reg  <= '0;
                                    pi_reg     <= '0;
                                    pj_reg     <= '0;
                                    larger_reg <= sba_pkg::BLOCK_INF;
                                    state_reg  <= S_PRRD;
                                end
                            end
                            sba_pkg::OP_READ_COL:
                            begin
                                if (in_bad_c)
                                    res_status_reg <= sba_pkg::ST_BAD;
                                else
                                begin
                                    res_bid_reg <= agg_reg[in_col];
                                    res_req_reg <= req_reg[in_col];
                                end
                            end
                            sba_pkg::OP_READ_SUM:
                            begin
                                if (in_bad_ce)
                                    res_status_reg <= sba_pkg::ST_BAD;
                                else
                                    state_reg <= S_SUMRD;
                            end
                            sba_pkg::OP_RESET:
                            begin
                                rcv_reg     <= '0;
                                clr_op_reg  <= 1'b1;
                                clr_cnt_reg <= '0;
                                for (int i = 0; i < COLUMNS; i++)
                                    agg_reg[i] <= sba_pkg::BLOCK_INF;
                                state_reg   <= S_CLEAR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SAW'(1);
                    if (int'(clr_cnt_reg) == SD - 1)
                    begin
                        clr_op_reg <= 1'b0;
                        state_reg  <= clr_op_reg ? S_DONE : S_IDLE;
                    end
                end

                // Advance the remainder of block_id by column_count
                S_MOD:
                begin
                    rem_reg     <= rem_next;
                    mod_sh_reg  <= {mod_sh_reg[sba_pkg::ID_W-2:0], 1'b0};
                    mod_cnt_reg <= mod_cnt_reg + MCW'(1);
                    if (int'(mod_cnt_reg) == sba_pkg::MOD_STEPS - 1)
                        state_reg <= S_ELWR;
                end

                S_SUMRD:
                begin
                    state_reg <= S_DONE;
                end

                S_ELWR:
                begin
                    if (el_mism)
                        res_status_reg <= sba_pkg::ST_BAD;
                    else
                    begin
                        agg_reg[it_col] <= '{vld: 1'b1, id: item_reg.block_id};
                        if (item_reg.element_index == 8'd0)
                            cm_reg[it_col] <= min_entry(cm_reg[it_col], el_next);
                    end
                    state_reg <= S_DONE;
                end

                S_PRRD:
                begin
                    state_reg <= S_PREV;
                end

                // Evaluate one worker entry of the current column
                S_PREV:
                begin
                    if (pr_hit)
                    begin
                        if (!marks_reg[pj_reg])
                        begin
                            exp_reg           <= exp_reg + WCW'(1);
                            marks_reg[pj_reg] <= 1'b1;
                        end
                        nt_vld_reg[pr_addr] <= 1'b0;
                    end
                    state_reg <= S_PRRD;
                    if (int'(pj_reg) == int'(wc_reg) - 1)
                    begin
                        req_reg[pi_reg] <= pr_m;
                        cm_reg[pi_reg]  <= larger_next;
                        larger_reg      <= sba_pkg::BLOCK_INF;
                        pj_reg          <= '0;
                        pi_reg          <= pi_reg + CIW'(1);
                        if (int'(pi_reg) == int'(cc_reg) - 1)
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        larger_reg <= larger_next;
                        pj_reg     <= pj_reg + WIW'(1);
                    end
                end

                // Load the result once the output register is free
                S_DONE:
                begin
                    if (!out_vld_reg || out_ch.ready)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && (!out_vld_reg || out_ch.ready))
        begin
            out_reg.status           <= res_status_reg;
            out_reg.all_in           <= (int'(rcv_reg) == int'(exp_reg));
            out_reg.expected_senders <= 5'(exp_reg);
            out_reg.valid_columns    <= 4'(vcols);
            out_reg.out_block_id     <= res_bid_reg.id;
            out_reg.out_block_valid  <= res_bid_reg.vld;
            out_reg.request_id       <= res_req_reg.id;
            out_reg.request_valid    <= res_req_reg.vld;
            out_reg.sum_value        <= ((item_reg.op == sba_pkg::OP_READ_SUM)
                                         && (res_status_reg == sba_pkg::ST_OK))
                                        ? sum_rd_reg : '0;
        end
    end

    assign out_ch.valid   = out_vld_reg;
    assign out_ch.payload = out_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("request taken while a request is in work");

    a_rcv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(rcv_reg) <= RCV_MAX)
        else $error("received count above its limit");

    a_marks_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREV) |-> ($countones(marks_reg) == int'(exp_reg)))
        else $error("sender marks disagree with expected count");

    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(exp_reg) <= int'(wc_reg))
        else $error("expected count above worker count");

endmodule
